// ===== rtl/core/dadv_pkg.sv =====
// Shared widths, codes, reciprocal constants and calendar tables for the date adder.
package dadv_pkg;

  localparam int DW    = 5;
  localparam int MW    = 4;
  localparam int YW    = 14;
  localparam int OFFW  = 23;
  localparam int WDW   = 3;
  localparam int STW   = 2;
  localparam int YSW   = 15;
  localparam int ZW    = 25;
  localparam int YOW   = 17;
  localparam int DOYW  = 9;
  localparam int CFG_IDXW = 1;

  // 30 whole 400-year eras; keeps every day number positive
  localparam logic [YSW-1:0] YEAR_SHIFT   = 15'd12000;
  localparam logic [YW-1:0]  YEAR_MIN_RST = 14'd1902;
  localparam logic [YW-1:0]  YEAR_MAX_RST = 14'd2037;

  localparam int DAYS_ERA = 146097;

  // floor(x / D) == (x * K) >> N whenever x * D < 2**N
  localparam int N_25   = 18;
  localparam int N_ERA  = 43;
  localparam int N_WD   = 28;
  localparam int N_1460 = 29;
  localparam int N_365  = 27;
  localparam int N_100  = 16;
  localparam int N_153  = 19;
  localparam logic [13:0] K_25   = 14'((64'd1 << N_25) / 64'd25 + 64'd1);
  localparam logic [25:0] K_ERA  = 26'((64'd1 << N_ERA) / 64'd146097 + 64'd1);
  localparam logic [25:0] K_WD   = 26'((64'd1 << N_WD) / 64'd7 + 64'd1);
  localparam logic [18:0] K_1460 = 19'((64'd1 << N_1460) / 64'd1460 + 64'd1);
  localparam logic [18:0] K_365  = 19'((64'd1 << N_365) / 64'd365 + 64'd1);
  localparam logic [9:0]  K_100  = 10'((64'd1 << N_100) / 64'd100 + 64'd1);
  localparam logic [11:0] K_153  = 12'((64'd1 << N_153) / 64'd153 + 64'd1);

  typedef enum logic [CFG_IDXW-1:0] {
    REG_YEAR_MIN = 1'b0,
    REG_YEAR_MAX = 1'b1
  } cfg_reg_t;

  typedef enum logic [STW-1:0] {
    ST_OK    = 2'd0,
    ST_YEAR  = 2'd1,
    ST_MONTH = 2'd2,
    ST_DAY   = 2'd3
  } status_t;

  typedef struct packed {
    logic            vld;
    status_t         st;
    logic [ZW-1:0]   z;
  } dadv_beat_t;

  // first day of month, counted from March 1; index 0 is March
  function automatic logic [DOYW-1:0] mstart(input logic [3:0] mp);
    logic [DOYW-1:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DW-1:0] mlen(input logic [MW-1:0] m);
    logic [DW-1:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] div25(input logic [12:0] x);
    logic [26:0] p;
    p = 27'(x) * 27'(K_25);
    return p[N_25 +: 9];
  endfunction

endpackage

// ===== rtl/core/date_add_days_with_validation.sv =====
// Gregorian date plus signed day offset, with input and result validation.
// Throughput: one beat per cycle; busy is low except around reset.
// The receiver cannot stall; every result shows for one cycle with done.
// Synchronous reset clears the pipeline valids and loads year limits 1902..2037.
module date_add_days_with_validation (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [dadv_pkg::DW-1:0]           day,
  input  logic [dadv_pkg::MW-1:0]           month,
  input  logic [dadv_pkg::YW-1:0]           year,
  input  logic signed [dadv_pkg::OFFW-1:0]  offset,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dadv_pkg::CFG_IDXW-1:0]     cfg_index,
  input  logic [dadv_pkg::YW-1:0]           cfg_data,
  output logic                              done,
  output logic [dadv_pkg::DW-1:0]           new_day,
  output logic [dadv_pkg::MW-1:0]           new_month,
  output logic [dadv_pkg::YW-1:0]           new_year,
  output logic [dadv_pkg::WDW-1:0]          weekday,
  output logic [dadv_pkg::STW-1:0]          status
);
  import dadv_pkg::*;

  logic [YW-1:0]          ymin, ymax;

  logic                   v1, v2, v3, v4;
  logic [DW-1:0]          d1, d2, d3;
  logic [MW-1:0]          m1;
  logic [YW-1:0]          y1, y2, y3;
  logic signed [OFFW-1:0] o1, o2, o3;
  status_t                st2, st3, st4;
  logic [YSW-1:0]         ys2, ys3;
  logic [DOYW-1:0]        dd2, dd3;
  logic [DW-1:0]          lim2, lim3;
  logic                   feb2, feb3;
  logic [8:0]             qa3, qb3, qc3, qd3;
  logic [ZW-1:0]          z4;
  dadv_beat_t             beat;

  status_t                st_s, st4_s;
  logic [3:0]             mp_s;
  logic                   div100_s, div400_s, leap_s;
  logic [DW-1:0]          lim_s;
  logic [ZW-1:0]          z_s;

  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      ymin <= YEAR_MIN_RST;
      ymax <= YEAR_MAX_RST;
    end else begin
      busy <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_YEAR_MIN: ymin <= cfg_data;
          REG_YEAR_MAX: ymax <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    if (y1 > ymax || y1 < ymin) begin
      st_s = ST_YEAR;
    end else if (m1 == 4'd0 || m1 > 4'd12) begin
      st_s = ST_MONTH;
    end else begin
      st_s = ST_OK;
    end
    mp_s = (m1 > 4'd2) ? m1 - 4'd3 : m1 + 4'd9;

    div100_s = (y3[1:0] == 2'b00) && ((y3 >> 2) == YW'(qc3) * YW'(25));
    div400_s = (y3[3:0] == 4'b0000) && ((y3 >> 4) == YW'(qd3) * YW'(25));
    leap_s   = (y3[1:0] == 2'b00) && (!div100_s || div400_s);
    lim_s    = lim3 + DW'(feb3 && leap_s);
    if (st3 != ST_OK) begin
      st4_s = st3;
    end else if (d3 == 5'd0 || d3 > lim_s) begin
      st4_s = ST_DAY;
    end else begin
      st4_s = ST_OK;
    end
    z_s = ZW'(ys3) * ZW'(365) + ZW'(ys3 >> 2) - ZW'(qa3) + ZW'(qb3) + ZW'(dd3) +
          {{(ZW-OFFW){o3[OFFW-1]}}, o3};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    d1 <= day;
    m1 <= month;
    y1 <= year;
    o1 <= offset;
    // checks, shifted year, day from March 1
    st2  <= st_s;
    ys2  <= YSW'(y1) + YEAR_SHIFT - YSW'(m1 <= 4'd2);
    dd2  <= mstart(mp_s) + DOYW'(d1) - DOYW'(1);
    lim2 <= mlen(m1);
    feb2 <= (m1 == 4'd2);
    y2   <= y1;
    d2   <= d1;
    o2   <= o1;
    // century and 400-year quotients
    st3  <= st2;
    ys3  <= ys2;
    dd3  <= dd2;
    lim3 <= lim2;
    feb3 <= feb2;
    y3   <= y2;
    d3   <= d2;
    o3   <= o2;
    qa3  <= div25(13'(ys2 >> 2));
    qb3  <= div25(13'(ys2 >> 4));
    qc3  <= div25(13'(y2 >> 2));
    qd3  <= div25(13'(y2 >> 4));
    // day number plus offset
    st4 <= st4_s;
    z4  <= z_s;
  end

  assign beat = '{vld: v4, st: st4, z: z4};

  dadv_split u_split (
    .clk       (clk),
    .rst       (rst),
    .beat      (beat),
    .ymin      (ymin),
    .ymax      (ymax),
    .done      (done),
    .new_day   (new_day),
    .new_month (new_month),
    .new_year  (new_year),
    .weekday   (weekday),
    .status    (status)
  );

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##12 done)
    else $error("accepted beat did not complete in 12 cycles");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |->
      (new_day == '0 && new_month == '0 && new_year == '0 && weekday == '0))
    else $error("error result carries nonzero date fields");

  a_ok_range: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_OK) |->
      (new_month >= 4'd1 && new_month <= 4'd12 && new_day >= 5'd1 && weekday <= 3'd6))
    else $error("ok result has out-of-range date fields");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(beat.vld, 8))
    else $error("done without a beat in the split pipeline");
`endif

endmodule

// ===== rtl/core/dadv_split.sv =====
// Day number to calendar date, weekday and final year range check.
module dadv_split (
  input  logic                         clk,
  input  logic                         rst,
  input  dadv_pkg::dadv_beat_t         beat,
  input  logic [dadv_pkg::YW-1:0]      ymin,
  input  logic [dadv_pkg::YW-1:0]      ymax,
  output logic                         done,
  output logic [dadv_pkg::DW-1:0]      new_day,
  output logic [dadv_pkg::MW-1:0]      new_month,
  output logic [dadv_pkg::YW-1:0]      new_year,
  output logic [dadv_pkg::WDW-1:0]     weekday,
  output logic [dadv_pkg::STW-1:0]     status
);
  import dadv_pkg::*;

  logic            v5, v6, v7, v8, v9, v10, v11;
  status_t         st5, st6, st7, st8, st9, st10, st11;

  logic [ZW-1:0]   z5, x5;
  logic [7:0]      era5;
  logic [22:0]     q7_5;
  logic [17:0]     doe6, doe7, doe8, doe9;
  logic [WDW-1:0]  wd6, wd7, wd8, wd9, wd10, wd11;
  logic [YOW-1:0]  yb6, yb7, yb8, yb9, ysh10, ysh11;
  logic [6:0]      q1460_7;
  logic [2:0]      c7;
  logic            e7;
  logic [8:0]      yoe8, yoe9;
  logic [1:0]      q100_9;
  logic [DOYW-1:0] doy10, doy11;
  logic [3:0]      mp11;

  logic [ZW-1:0]   x_s;
  logic [50:0]     pe_s, pw_s;
  logic [36:0]     p1460_s, p365_s;
  logic [17:0]     num_s;
  logic [18:0]     p100_s;
  logic [10:0]     n153_s;
  logic [22:0]     p153_s;
  logic [MW-1:0]   mon_s;
  logic [DW-1:0]   dd_s;
  logic [YOW-1:0]  yres_s;
  logic            inr_s;

  always_comb begin
    x_s     = beat.z + ZW'(3);
    pe_s    = 51'(beat.z) * 51'(K_ERA);
    pw_s    = 51'(x_s) * 51'(K_WD);
    p1460_s = 37'(doe6) * 37'(K_1460);
    num_s   = doe7 - 18'(q1460_7) + 18'(c7) - 18'(e7);
    p365_s  = 37'(num_s) * 37'(K_365);
    p100_s  = 19'(yoe8) * 19'(K_100);
    n153_s  = 11'(doy10) * 11'd5 + 11'd2;
    p153_s  = 23'(n153_s) * 23'(K_153);
    mon_s   = (mp11 < 4'd10) ? mp11 + 4'd3 : mp11 - 4'd9;
    dd_s    = DW'(doy11 - mstart(mp11) + DOYW'(1));
    yres_s  = ysh11 + YOW'(mon_s <= 4'd2);
    inr_s   = (yres_s >= YOW'(ymin) + YOW'(YEAR_SHIFT)) &&
              (yres_s <= YOW'(ymax) + YOW'(YEAR_SHIFT));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5   <= 1'b0;
      v6   <= 1'b0;
      v7   <= 1'b0;
      v8   <= 1'b0;
      v9   <= 1'b0;
      v10  <= 1'b0;
      v11  <= 1'b0;
      done <= 1'b0;
    end else begin
      v5   <= beat.vld;
      v6   <= v5;
      v7   <= v6;
      v8   <= v7;
      v9   <= v8;
      v10  <= v9;
      v11  <= v10;
      done <= v11;
    end
  end

  always_ff @(posedge clk) begin
    // era and weekday quotients
    st5  <= beat.st;
    z5   <= beat.z;
    x5   <= x_s;
    era5 <= pe_s[N_ERA +: 8];
    q7_5 <= pw_s[N_WD +: 23];
    // day of era
    st6  <= st5;
    doe6 <= 18'(z5 - ZW'(era5) * ZW'(DAYS_ERA));
    wd6  <= WDW'(x5 - ZW'(q7_5) * ZW'(7));
    yb6  <= YOW'(era5) * YOW'(400);
    // leap corrections
    st7     <= st6;
    doe7    <= doe6;
    wd7     <= wd6;
    yb7     <= yb6;
    q1460_7 <= p1460_s[N_1460 +: 7];
    c7      <= 3'(doe6 >= 18'd36524) + 3'(doe6 >= 18'd73048) +
               3'(doe6 >= 18'd109572) + 3'(doe6 >= 18'd146096);
    e7      <= (doe6 == 18'd146096);
    // year of era
    st8  <= st7;
    doe8 <= doe7;
    wd8  <= wd7;
    yb8  <= yb7;
    yoe8 <= p365_s[N_365 +: 9];
    // century count
    st9    <= st8;
    doe9   <= doe8;
    wd9    <= wd8;
    yb9    <= yb8;
    yoe9   <= yoe8;
    q100_9 <= p100_s[N_100 +: 2];
    // day of year from March 1
    st10  <= st9;
    wd10  <= wd9;
    doy10 <= DOYW'(doe9 - (18'(yoe9) * 18'd365 + 18'(yoe9 >> 2) - 18'(q100_9)));
    ysh10 <= yb9 + YOW'(yoe9);
    // month index
    st11  <= st10;
    wd11  <= wd10;
    doy11 <= doy10;
    ysh11 <= ysh10;
    mp11  <= p153_s[N_153 +: 4];
    // result
    if (st11 == ST_OK && inr_s) begin
      new_day   <= dd_s;
      new_month <= mon_s;
      new_year  <= YW'(yres_s - YOW'(YEAR_SHIFT));
      weekday   <= wd11;
      status    <= ST_OK;
    end else begin
      new_day   <= '0;
      new_month <= '0;
      new_year  <= '0;
      weekday   <= '0;
      status    <= (st11 == ST_OK) ? ST_YEAR : st11;
    end
  end

endmodule

// ===== dv/date_add_days_with_validation_checker.sv =====
// Checker for the date adder: tracks year limits, predicts each result and compares it.
`timescale 1ns / 1ps
module date_add_days_with_validation_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic [dadv_pkg::DW-1:0]           day,
  input  logic [dadv_pkg::MW-1:0]           month,
  input  logic [dadv_pkg::YW-1:0]           year,
  input  logic signed [dadv_pkg::OFFW-1:0]  offset,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [dadv_pkg::CFG_IDXW-1:0]     cfg_index,
  input  logic [dadv_pkg::YW-1:0]           cfg_data,
  input  logic                              done,
  input  logic [dadv_pkg::DW-1:0]           new_day,
  input  logic [dadv_pkg::MW-1:0]           new_month,
  input  logic [dadv_pkg::YW-1:0]           new_year,
  input  logic [dadv_pkg::WDW-1:0]          weekday,
  input  logic [dadv_pkg::STW-1:0]          status,
  input  logic                              wrap_up,
  output int                                errors,
  output int                                outstanding,
  output int                                good_dates
);
  import dadv_pkg::*;

  // 50 whole 400-year eras, so day counts never go negative
  localparam longint ERA_BIAS = 20000;

  typedef struct packed {
    logic [DW-1:0]  d;
    logic [MW-1:0]  m;
    logic [YW-1:0]  y;
    logic [WDW-1:0] wd;
    status_t        st;
  } date_out_t;

  date_out_t future_dates[$];
  date_out_t want;
  int        lim_lo;
  int        lim_hi;
  bit        wrapped;

  initial begin
    errors      = 0;
    outstanding = 0;
    good_dates  = 0;
    wrapped     = 1'b0;
    lim_lo      = int'(YEAR_MIN_RST);
    lim_hi      = int'(YEAR_MAX_RST);
  end

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 40) $display("%0t ns: MISMATCH %s", $time, msg);
  endtask

  function automatic date_out_t shift_date(input logic [DW-1:0] d, input logic [MW-1:0] m,
                                           input logic [YW-1:0] y,
                                           input logic signed [OFFW-1:0] off,
                                           input int lo, input int hi);
    date_out_t r;
    longint    yy, mm, dd, len, yc, era, yoe, mp, doy, doe, z;
    bit        leap;
    r  = '0;
    yy = longint'(y);
    mm = longint'(m);
    dd = longint'(d);
    if (yy > hi || yy < lo) begin
      r.st = ST_YEAR;
    end else if (mm < 1 || mm > 12) begin
      r.st = ST_MONTH;
    end else begin
      leap = (yy % 4 == 0) && ((yy % 100 != 0) || (yy % 400 == 0));
      case (mm)
        2:          len = leap ? 29 : 28;
        4, 6, 9, 11: len = 30;
        default:    len = 31;
      endcase
      if (dd < 1 || dd > len) r.st = ST_DAY;
    end
    if (r.st == ST_OK) begin
      // day count from March 1 of the biased year zero; years start in March
      yc  = yy + ERA_BIAS - ((mm <= 2) ? 1 : 0);
      era = yc / 400;
      yoe = yc - era * 400;
      mp  = (mm > 2) ? mm - 3 : mm + 9;
      doy = (153 * mp + 2) / 5 + dd - 1;
      z   = era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy + longint'(off);
      era = z / 146097;
      doe = z - era * 146097;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp  = (5 * doy + 2) / 153;
      dd  = doy - (153 * mp + 2) / 5 + 1;
      mm  = (mp < 10) ? mp + 3 : mp - 9;
      yy  = yoe + era * 400 + ((mm <= 2) ? 1 : 0) - ERA_BIAS;
      if (yy > hi || yy < lo) begin
        r.st = ST_YEAR;
      end else begin
        r.d  = dd[DW-1:0];
        r.m  = mm[MW-1:0];
        r.y  = yy[YW-1:0];
        z    = (z + 3) % 7;
        r.wd = z[WDW-1:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      future_dates.delete();
      lim_lo = int'(YEAR_MIN_RST);
      lim_hi = int'(YEAR_MAX_RST);
    end else begin
      if (done) begin
        if (future_dates.size() == 0) begin
          flag_error("result beat with no date outstanding");
        end else begin
          want = future_dates.pop_front();
          if (status !== want.st)
            flag_error($sformatf("status %0d, want %0d", status, want.st));
          if (new_day !== want.d)
            flag_error($sformatf("new_day %0d, want %0d", new_day, want.d));
          if (new_month !== want.m)
            flag_error($sformatf("new_month %0d, want %0d", new_month, want.m));
          if (new_year !== want.y)
            flag_error($sformatf("new_year %0d, want %0d", new_year, want.y));
          if (weekday !== want.wd)
            flag_error($sformatf("weekday %0d, want %0d", weekday, want.wd));
          if (want.st == ST_OK) good_dates++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_YEAR_MIN) lim_lo = int'(cfg_data);
        else lim_hi = int'(cfg_data);
      end
      if (start && !busy)
        future_dates.push_back(shift_date(day, month, year, offset, lim_lo, lim_hi));
      if (wrap_up && !wrapped) begin
        wrapped = 1'b1;
        if (future_dates.size() != 0)
          flag_error($sformatf("%0d dates never returned", future_dates.size()));
      end
    end
    outstanding <= future_dates.size();
  end

endmodule

// ===== dv/date_add_days_with_validation_tb.sv =====
// Testbench top for the date adder: clock, reset, year-limit phases and date stimulus.
`timescale 1ns / 1ps
module date_add_days_with_validation_tb;
  import dadv_pkg::*;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [DW-1:0]           day;
  logic [MW-1:0]           month;
  logic [YW-1:0]           year;
  logic signed [OFFW-1:0]  offset;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDXW-1:0]     cfg_index;
  logic [YW-1:0]           cfg_data;
  logic                    done;
  logic [DW-1:0]           new_day;
  logic [MW-1:0]           new_month;
  logic [YW-1:0]           new_year;
  logic [WDW-1:0]          weekday;
  logic [STW-1:0]          status;
  logic                    wrap_up;
  int                      errors;
  int                      outstanding;
  int                      good_dates;

  int cur_lo = 1902;
  int cur_hi = 2037;
  int n_sent = 0;
  int n_settings = 1;
  bit steady = 1'b0;

  date_add_days_with_validation i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .day       (day),
    .month     (month),
    .year      (year),
    .offset    (offset),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .new_day   (new_day),
    .new_month (new_month),
    .new_year  (new_year),
    .weekday   (weekday),
    .status    (status)
  );

  date_add_days_with_validation_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("date_add_days_with_validation test failed");
    $finish;
  end

  task automatic send_date(input logic [DW-1:0] d, input logic [MW-1:0] m,
                           input logic [YW-1:0] y, input logic signed [OFFW-1:0] o);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) gap = 0;
    else if (r < 85) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 80);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    day    <= d;
    month  <= m;
    year   <= y;
    offset <= o;
    do @(posedge clk); while (busy);
    n_sent++;
  endtask

  task automatic send_random_date();
    logic [DW-1:0] d;
    logic [MW-1:0] m;
    logic [YW-1:0] y;
    int            o;
    int            yr;
    int            target;
    int            span;
    if ($urandom_range(0, 9) < 8) begin
      if ($urandom_range(0, 7) == 0) yr = ($urandom_range(0, 1) == 1) ? cur_hi : cur_lo;
      else yr = $urandom_range(cur_hi, cur_lo);
      y = yr[YW-1:0];
      m = MW'($urandom_range(1, 12));
      d = ($urandom_range(0, 3) != 0) ? DW'($urandom_range(1, 28)) :
                                        DW'($urandom_range(29, 31));
      case ($urandom_range(0, 9))
        0, 1, 2, 3: o = int'($urandom_range(0, 800)) - 400;
        4, 5:       o = int'($urandom_range(0, 400000)) - 200000;
        6, 7:       o = $urandom;
        8: begin
          case ($urandom_range(0, 4))
            0:       o = 0;
            1:       o = 1;
            2:       o = -1;
            3:       o = 4194303;
            default: o = -4194304;
          endcase
        end
        default: begin
          // land within about two years of a limit
          target = ($urandom_range(0, 1) == 1) ? cur_hi : cur_lo;
          span   = target - yr;
          o = span * 365 + span / 4 - span / 100 + span / 400
              + int'($urandom_range(0, 1600)) - 800;
        end
      endcase
    end else begin
      d = DW'($urandom_range(0, 31));
      m = MW'($urandom_range(0, 15));
      y = YW'($urandom_range(0, 9999));
      o = $urandom;
    end
    send_date(d, m, y, o[OFFW-1:0]);
  endtask

  task automatic send_random_dates(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      send_random_date();
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_limits(input int lo, input int hi);
    cfg_valid <= 1'b1;
    cfg_index <= REG_YEAR_MIN;
    cfg_data  <= lo[YW-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_YEAR_MAX;
    cfg_data  <= hi[YW-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_lo = lo;
    cur_hi = hi;
    n_settings++;
    @(posedge clk);
  endtask

  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    day       <= '0;
    month     <= '0;
    year      <= '0;
    offset    <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_YEAR_MIN;
    cfg_data  <= '0;
    wrap_up   <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset limits 1902..2037
    send_date(5'd1,  4'd1,  14'd1902, OFFW'(0));
    send_date(5'd31, 4'd12, 14'd2037, OFFW'(0));
    send_date(5'd31, 4'd12, 14'd2037, OFFW'(1));
    send_date(5'd1,  4'd1,  14'd1902, OFFW'(-1));
    send_date(5'd0,  4'd0,  14'd0,    OFFW'(0));
    send_date(5'd31, 4'd15, 14'd1901, OFFW'(7));
    send_date(5'd15, 4'd0,  14'd2000, OFFW'(5));
    send_date(5'd15, 4'd13, 14'd2000, OFFW'(5));
    send_date(5'd15, 4'd15, 14'd2000, OFFW'(5));
    send_date(5'd29, 4'd2,  14'd2000, OFFW'(0));
    send_date(5'd29, 4'd2,  14'd2001, OFFW'(0));
    send_date(5'd0,  4'd6,  14'd2020, OFFW'(0));
    send_date(5'd31, 4'd4,  14'd2020, OFFW'(0));
    send_date(5'd28, 4'd2,  14'd2024, OFFW'(1));
    send_random_dates(200);
    wait_for_results();

    set_limits(1, 9999);
    send_date(5'd1,  4'd1,  14'd1,    OFFW'(0));
    send_date(5'd1,  4'd1,  14'd1,    OFFW'(-1));
    send_date(5'd31, 4'd12, 14'd9999, OFFW'(0));
    send_date(5'd31, 4'd12, 14'd9999, OFFW'(1));
    send_date(5'd1,  4'd1,  14'd5000, OFFW'(-4194304));
    send_date(5'd1,  4'd1,  14'd5000, OFFW'(4194303));
    send_date(5'd29, 4'd2,  14'd1900, OFFW'(0));
    send_date(5'd29, 4'd2,  14'd1600, OFFW'(0));
    send_date(5'd31, 4'd1,  14'd1,    OFFW'(4194303));
    send_random_dates(300);
    wait_for_results();

    // year zero only valid with a zero lower limit
    set_limits(0, 9999);
    send_date(5'd29, 4'd2,  14'd0,    OFFW'(0));
    send_date(5'd1,  4'd3,  14'd0,    OFFW'(-60));
    send_date(5'd31, 4'd12, 14'd9999, OFFW'(-4194304));
    send_random_dates(220);
    wait_for_results();

    // inverted limits reject every year
    set_limits(2000, 1999);
    send_random_dates(120);
    wait_for_results();

    set_limits(9999, 9999);
    send_random_dates(120);
    wait_for_results();

    set_limits(0, 0);
    send_random_dates(100);
    wait_for_results();

    set_limits(1600, 2400);
    send_random_dates(260);
    wait_for_results();

    repeat (30) @(posedge clk);
    wrap_up <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Sent %0d dates over %0d year-limit settings, %0d came back as valid dates.",
             n_sent, n_settings, good_dates);
    $display("Settings included the reset limits, full range, year zero and inverted limits.");
    if (errors == 0) begin
      $display("date_add_days_with_validation test passed");
    end else begin
      $display("date_add_days_with_validation test failed");
    end
    $finish;
  end

endmodule
